[rtl/sqhtc_pkg.sv]
// sqhtc_pkg: shared types and codes for the stack/queue/heap trace classifier.
// No dependencies.
`default_nettype none
package sqhtc_pkg;
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [2:0] VERDICT_STACK    = 3'd0;
    localparam logic [2:0] VERDICT_QUEUE    = 3'd1;
    localparam logic [2:0] VERDICT_HEAP     = 3'd2;
    localparam logic [2:0] VERDICT_NOT_SURE = 3'd3;
    localparam logic [2:0] VERDICT_IMPOSS   = 3'd4;
    localparam logic [2:0] VERDICT_OVERFLOW = 3'd5;

    typedef struct packed {
        logic valid;
        logic is_pop;
        logic last;
    } t_item_ctl;
endpackage
`default_nettype wire

[rtl/sqhtc_if.sv]
// Channel interfaces: trace item input and verdict output.
// Uses no package.
`default_nettype none
interface sqhtc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] value;
    logic        end_of_trace;
    modport source (output valid, action, value, end_of_trace, input ready);
    modport sink (input valid, action, value, end_of_trace, output ready);
endinterface

interface sqhtc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    modport source (output valid, verdict, input ready);
    modport sink (input valid, verdict, output ready);
endinterface
`default_nettype wire

[rtl/sqhtc_front.sv]
// sqhtc_front: accepts trace items, converts values to ordered keys and
// buffers them in a two-entry queue. Depends on sqhtc_pkg.
`default_nettype none
module sqhtc_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_action,
    input  wire logic [31:0]            i_value,
    input  wire logic                   i_end_of_trace,
    output sqhtc_pkg::t_item_ctl        o_ctl,
    output logic [VALUE_WIDTH-1:0]      o_key,
    input  wire logic                   i_take
);
    logic [VALUE_WIDTH+31:0] wide;
    logic [VALUE_WIDTH-1:0]  ext;
    logic [VALUE_WIDTH-1:0]  key;
    logic [VALUE_WIDTH-1:0]  r_key [2];
    logic                    r_pop [2];
    logic                    r_last [2];
    logic                    r_wp, r_rp;
    logic [1:0]              r_cnt;
    logic                    push, take;

    assign wide = {(VALUE_WIDTH)'(0), i_value};
    assign ext  = wide[VALUE_WIDTH-1:0];
    assign key  = {~ext[VALUE_WIDTH-1], ext[VALUE_WIDTH-2:0]};

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign take    = i_take && (r_cnt != 2'd0);

    assign o_ctl.valid  = (r_cnt != 2'd0);
    assign o_ctl.is_pop = r_pop[r_rp];
    assign o_ctl.last   = r_last[r_rp];
    assign o_key        = r_key[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_key[r_wp]  <= key;
            r_pop[r_wp]  <= (i_action == sqhtc_pkg::ACT_POP);
            r_last[r_wp] <= i_end_of_trace;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, take};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("front queue count out of range");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_ctl.valid)
        else $error("front queue shows item while empty");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !take) |=> (r_cnt == 2'd2))
        else $error("front queue lost an entry");
endmodule
`default_nettype wire

[rtl/sqhtc_back.sv]
// sqhtc_back: stack, FIFO and binary max-heap stores with match tracking and
// the verdict register. Depends on sqhtc_pkg.
`default_nettype none
module sqhtc_back #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire sqhtc_pkg::t_item_ctl   i_ctl,
    input  wire logic [VALUE_WIDTH-1:0] i_key,
    output logic                        o_take,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [2:0]                  o_verdict
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = VALUE_WIDTH;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;
    localparam logic [2:0] S_VERD   = 3'd7;

    logic [VW-1:0] stack_mem [CAPACITY];
    logic [VW-1:0] queue_mem [CAPACITY];
    logic [VW-1:0] heap_mem  [CAPACITY];

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_idx, n_idx;
    logic [VW-1:0] r_cur, n_cur, r_key, n_key;
    logic          r_last, n_last;
    logic          r_sm, n_sm, r_qm, n_qm, r_hm, n_hm;
    logic          r_uf, n_uf, r_of, n_of;
    logic          r_rok, n_rok;
    logic          r_ovalid, n_ovalid;
    logic [2:0]    r_verdict, n_verdict;

    logic [VW-1:0] stack_rd, queue_rd, heap_rd_a, heap_rd_b;
    logic [AW-1:0] stack_ra, queue_ra, heap_ra_a, heap_ra_b;
    logic          stack_we, heap_we;
    logic [AW-1:0] heap_wa;
    logic [VW-1:0] heap_wd;
    logic [CW-1:0] parent;
    logic [CW:0]   lchild, rchild;
    logic [1:0]    hits;
    logic          out_free;
    logic          pick_right;
    logic [VW-1:0] big;
    logic [CW-1:0] big_idx;

    assign out_free = !r_ovalid || i_ready;
    assign o_valid   = r_ovalid;
    assign o_verdict = r_verdict;
    assign o_take    = (r_state == S_IDLE) && i_ctl.valid;

    assign parent     = (r_idx - CW'(1)) >> 1;
    assign lchild     = {r_idx, 1'b1};
    assign rchild     = lchild + (CW+1)'(1);
    assign pick_right = r_rok && (heap_rd_b > heap_rd_a);
    assign big        = pick_right ? heap_rd_b : heap_rd_a;
    assign big_idx    = pick_right ? rchild[CW-1:0] : lchild[CW-1:0];
    assign hits       = {1'b0, r_sm} + {1'b0, r_qm} + {1'b0, r_hm};

    always_comb begin
        stack_ra  = AW'(r_cnt - CW'(1));
        queue_ra  = r_head;
        heap_ra_a = '0;
        heap_ra_b = AW'(r_cnt - CW'(1));
        stack_we  = 1'b0;
        heap_we   = 1'b0;
        heap_wa   = AW'(r_idx);
        heap_wd   = r_cur;
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_head    = r_head;
        n_tail    = r_tail;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_key     = r_key;
        n_last    = r_last;
        n_sm      = r_sm;
        n_qm      = r_qm;
        n_hm      = r_hm;
        n_uf      = r_uf;
        n_of      = r_of;
        n_rok     = r_rok;
        n_ovalid  = r_ovalid && !i_ready;
        n_verdict = r_verdict;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.valid) begin
                    n_last  = i_ctl.last;
                    n_key   = i_key;
                    n_state = i_ctl.last ? S_VERD : S_IDLE;
                    if (!r_uf && !r_of) begin
                        if (!i_ctl.is_pop) begin
                            if (r_cnt >= CW'(CAPACITY)) begin
                                n_of = 1'b1;
                            end else begin
                                stack_we = 1'b1;
                                n_tail   = (r_tail == AW'(CAPACITY - 1)) ? '0 : r_tail + AW'(1);
                                n_idx    = r_cnt;
                                n_cur    = i_key;
                                n_cnt    = r_cnt + CW'(1);
                                n_state  = S_UP_RD;
                            end
                        end else begin
                            if (r_cnt == '0) begin
                                n_uf = 1'b1;
                            end else begin
                                n_cnt   = r_cnt - CW'(1);
                                n_head  = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
                                n_state = S_POP;
                            end
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    heap_we = 1'b1;
                    n_state = S_FIN;
                end else begin
                    heap_ra_a = AW'(parent);
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                heap_we = 1'b1;
                if (heap_rd_a >= r_cur) begin
                    n_state = S_FIN;
                end else begin
                    heap_wd = heap_rd_a;
                    n_idx   = parent;
                    n_state = S_UP_RD;
                end
            end
            S_POP: begin
                if (stack_rd != r_key) n_sm = 1'b0;
                if (queue_rd != r_key) n_qm = 1'b0;
                if (heap_rd_a != r_key) n_hm = 1'b0;
                n_cur   = heap_rd_b;
                n_idx   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (lchild >= {1'b0, r_cnt}) begin
                    heap_we = 1'b1;
                    n_state = S_FIN;
                end else begin
                    heap_ra_a = AW'(lchild);
                    heap_ra_b = AW'(rchild);
                    n_rok     = (rchild < {1'b0, r_cnt});
                    n_state   = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                heap_we = 1'b1;
                if (big > r_cur) begin
                    heap_wd = big;
                    n_idx   = big_idx;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = r_last ? S_VERD : S_IDLE;
            end
            S_VERD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_of)              n_verdict = sqhtc_pkg::VERDICT_OVERFLOW;
                    else if (r_uf)         n_verdict = sqhtc_pkg::VERDICT_IMPOSS;
                    else if (hits >= 2'd2) n_verdict = sqhtc_pkg::VERDICT_NOT_SURE;
                    else if (r_sm)         n_verdict = sqhtc_pkg::VERDICT_STACK;
                    else if (r_qm)         n_verdict = sqhtc_pkg::VERDICT_QUEUE;
                    else if (r_hm)         n_verdict = sqhtc_pkg::VERDICT_HEAP;
                    else                   n_verdict = sqhtc_pkg::VERDICT_IMPOSS;
                    n_cnt   = '0;
                    n_head  = '0;
                    n_tail  = '0;
                    n_sm    = 1'b1;
                    n_qm    = 1'b1;
                    n_hm    = 1'b1;
                    n_uf    = 1'b0;
                    n_of    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            stack_mem[AW'(r_cnt)] <= i_key;
            queue_mem[r_tail]     <= i_key;
        end
        if (heap_we) heap_mem[heap_wa] <= heap_wd;
        stack_rd  <= stack_mem[stack_ra];
        queue_rd  <= queue_mem[queue_ra];
        heap_rd_a <= heap_mem[heap_ra_a];
        heap_rd_b <= heap_mem[heap_ra_b];
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cur     <= n_cur;
        r_key     <= n_key;
        r_rok     <= n_rok;
        r_verdict <= n_verdict;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_last   <= 1'b0;
            r_sm     <= 1'b1;
            r_qm     <= 1'b1;
            r_hm     <= 1'b1;
            r_uf     <= 1'b0;
            r_of     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_last   <= n_last;
            r_sm     <= n_sm;
            r_qm     <= n_qm;
            r_hm     <= n_hm;
            r_uf     <= n_uf;
            r_of     <= n_of;
            r_ovalid <= n_ovalid;
        end
    end

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("item count above capacity");
    a_one_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_uf && r_of))
        else $error("underflow and overflow both set");
    a_clear_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VERD && out_free) |=> (r_cnt == '0 && r_sm && r_qm && r_hm))
        else $error("state not cleared after verdict");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_state == S_IDLE))
        else $error("item taken while busy");
endmodule
`default_nettype wire

[rtl/stack_queue_heap_trace_classifier.sv]
// Top level of the stack/queue/heap trace classifier: front buffer and back end.
// Depends on sqhtc_pkg, sqhtc_if, sqhtc_front, sqhtc_back.
//
//  channel   dir  fields                           transfer
//  i_in      in   action, value, end_of_trace      valid & ready
//  o_res     out  verdict (one per last item)      valid & ready
//
// Push: stores the key in stack and FIFO, then sifts it up the heap. Pop: checks
// stack, FIFO and heap tops against the key, then sifts the last heap entry down
// from the root. No new item is taken until sifting ends; ignored items are taken
// without effect. The last item adds a verdict state that also clears all trace state.
// Reset: synchronous, active low; store contents are not cleared.
// Two-entry input buffer takes items while the back end works or the
// verdict register waits on o_res.ready.
`default_nettype none
module stack_queue_heap_trace_classifier #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sqhtc_in_if.sink    i_in,
    sqhtc_out_if.source o_res
);
    sqhtc_pkg::t_item_ctl   ctl;
    logic [VALUE_WIDTH-1:0] key;
    logic                   take;

    sqhtc_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_action       (i_in.action),
        .i_value        (i_in.value),
        .i_end_of_trace (i_in.end_of_trace),
        .o_ctl          (ctl),
        .o_key          (key),
        .i_take         (take)
    );

    sqhtc_back #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_key     (key),
        .o_take    (take),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_verdict (o_res.verdict)
    );
endmodule
`default_nettype wire
